// ----- hdl/ihex_pkg.sv -----
// Shared types, codes and helpers for the HEX record parser.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package ihex_pkg;

  localparam int unsigned LineLimitDefault = 599;

  localparam logic [7:0] CharColon   = 8'h3A;
  localparam logic [7:0] CharNewline = 8'h0A;

  localparam logic [7:0] RecData = 8'h00;
  localparam logic [7:0] RecEof  = 8'h01;
  localparam logic [7:0] RecExt  = 8'h04;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_SHORT   = 3'd0,
    ERR_HEADER  = 3'd1,
    ERR_DATA    = 3'd2,
    ERR_EXT     = 3'd3,
    ERR_NO_DATA = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic [31:0] min_addr;
    logic [31:0] max_addr;
  } out_item_t;

  // status from the parser core to the top level
  typedef struct packed {
    logic stopped;
  } core_stat_t;

  // bit 4 set marks a character that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

endpackage

// ----- hdl/ihex_in_stage.sv -----
// Input register of the HEX record parser.
// Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ihex_pkg::in_item_t in_data_i,
  input  logic              take_i,
  output logic              valid_o,
  output ihex_pkg::in_item_t data_o
);

  logic               valid_q;
  logic               valid_d;
  ihex_pkg::in_item_t data_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hdl/ihex_core.sv -----
// Parser state and per-character decode of the HEX record parser.
// Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_core #(
  parameter int unsigned LINE_LIMIT = ihex_pkg::LineLimitDefault,
  localparam int unsigned LpW = $clog2(LINE_LIMIT + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  ihex_pkg::in_item_t  item_i,
  output logic                emit_o,
  output ihex_pkg::out_item_t result_o,
  output ihex_pkg::core_stat_t stat_o,
  output logic [LpW-1:0]      line_pos_o
);

  localparam logic [LpW-1:0] PosLimit = LpW'(LINE_LIMIT);
  localparam logic [LpW-1:0] MinLine  = LpW'(11);

  logic [LpW-1:0] lp_q, lp_d;
  logic [4:0]     hold_q, hold_d;
  logic [7:0]     count_q, count_d;
  logic [15:0]    offset_q, offset_d;
  logic [7:0]     rkind_q, rkind_d;
  logic           hbad_q, hbad_d;
  logic [7:0]     idx_q, idx_d;
  logic [7:0]     ext_q, ext_d;
  logic [15:0]    upper_q, upper_d;
  logic [31:0]    base_q, base_d;
  logic [31:0]    low_q, low_d;
  logic [31:0]    high_q, high_d;
  logic           saw_q, saw_d;
  logic           stop_q, stop_d;

  function automatic logic pending(input logic [7:0] k, input logic [7:0] n,
                                   input logic [7:0] i);
    logic r;
    r = 1'b0;
    if (k == ihex_pkg::RecData) r = (i < n);
    else if (k == ihex_pkg::RecExt) r = (i < 8'd2);
    return r;
  endfunction

  always_comb begin
    logic [4:0]     v;
    logic [3:0]     vv;
    logic [LpW-1:0] p;
    logic [LpW-1:0] pn;
    logic           do_fail;
    ihex_pkg::err_e fcode;
    logic           do_finish;
    logic           do_data;
    logic           done_rec;
    logic           complete;
    logic [7:0]     b;
    logic [31:0]    daddr;
    logic [31:0]    rend;

    lp_d = lp_q; hold_d = hold_q; count_d = count_q; offset_d = offset_q;
    rkind_d = rkind_q; hbad_d = hbad_q; idx_d = idx_q; ext_d = ext_q;
    upper_d = upper_q; base_d = base_q; low_d = low_q; high_d = high_q;
    saw_d = saw_q; stop_d = stop_q;

    v         = ihex_pkg::hex_value(item_i.ch);
    vv        = v[4] ? 4'd0 : v[3:0];
    p         = lp_q;
    pn        = lp_q + LpW'(1);
    do_fail   = 1'b0;
    fcode     = ihex_pkg::ERR_SHORT;
    do_finish = 1'b0;
    do_data   = 1'b0;
    done_rec  = 1'b0;
    complete  = 1'b0;
    b         = {hold_q[3:0], v[3:0]};
    daddr     = base_q + {24'd0, idx_q};
    rend      = base_q + {24'd0, count_q};

    emit_o   = 1'b0;
    result_o = '0;

    if (fire_i && !stop_q) begin
      if (item_i.end_mark) begin
        lp_d = '0;
        if (lp_q != '0 && lp_q < MinLine) begin
          do_fail = 1'b1;
        end else if (lp_q != '0 && pending(rkind_q, count_q, idx_q)) begin
          do_fail = 1'b1;
          fcode   = (rkind_q == ihex_pkg::RecExt) ? ihex_pkg::ERR_EXT : ihex_pkg::ERR_DATA;
        end else begin
          do_finish = 1'b1;
        end
      end else begin
        if (p == '0) begin
          if (item_i.ch != ihex_pkg::CharColon) begin
            do_fail = 1'b1;
          end else begin
            count_d = '0; offset_d = '0; rkind_d = '0;
            hbad_d = 1'b0; idx_d = '0; hold_d = '0;
          end
        end else if (p <= LpW'(8)) begin
          hbad_d = hbad_q | v[4];
          if (p <= LpW'(2)) count_d = {count_q[3:0], vv};
          else if (p <= LpW'(6)) offset_d = {offset_q[11:0], vv};
          else rkind_d = {rkind_q[3:0], vv};
        end else begin
          // record base is settled once the header is in
          if (p == LpW'(9)) base_d = {upper_q, offset_q};
          if (p == LpW'(10)) begin
            if (hbad_q) begin
              do_fail = 1'b1;
              fcode   = ihex_pkg::ERR_HEADER;
            end else if (rkind_q == ihex_pkg::RecEof) begin
              do_finish = 1'b1;
            end else if (rkind_q == ihex_pkg::RecExt && count_q != 8'd2) begin
              do_fail = 1'b1;
              fcode   = ihex_pkg::ERR_EXT;
            end else if (rkind_q == ihex_pkg::RecData && count_q == 8'd0) begin
              complete = 1'b1;
              done_rec = 1'b1;
            end
          end
          if (!do_fail && !do_finish && !done_rec && pending(rkind_q, count_q, idx_q)) begin
            if (p[0]) begin
              hold_d = v;
            end else if (v[4] || hold_q[4]) begin
              do_fail = 1'b1;
              fcode   = (rkind_q == ihex_pkg::RecExt) ? ihex_pkg::ERR_EXT : ihex_pkg::ERR_DATA;
            end else if (rkind_q == ihex_pkg::RecExt) begin
              if (idx_q == 8'd0) ext_d = b;
              else upper_d = {ext_q, b};
              idx_d = idx_q + 8'd1;
            end else begin
              idx_d   = idx_q + 8'd1;
              do_data = 1'b1;
              if (idx_d == count_q) complete = 1'b1;
            end
          end
        end

        // line end: newline or length cut
        if (!do_fail && !do_finish) begin
          lp_d = pn;
          if (item_i.ch == ihex_pkg::CharNewline || pn >= PosLimit) begin
            lp_d = '0;
            if (!do_data) begin
              if (pn < MinLine) begin
                do_fail = 1'b1;
              end else if (pending(rkind_d, count_d, idx_d)) begin
                do_fail = 1'b1;
                fcode   = (rkind_d == ihex_pkg::RecExt) ? ihex_pkg::ERR_EXT : ihex_pkg::ERR_DATA;
              end
            end
          end
        end
      end

      if (complete) begin
        if (base_q < low_q) low_d = base_q;
        if (rend > high_q) high_d = rend;
        saw_d = 1'b1;
      end

      if (do_fail || (do_finish && !saw_q)) begin
        stop_d              = 1'b1;
        emit_o              = 1'b1;
        result_o.kind       = ihex_pkg::KIND_ERROR;
        result_o.error_code = do_fail ? fcode : ihex_pkg::ERR_NO_DATA;
      end else if (do_finish) begin
        stop_d            = 1'b1;
        emit_o            = 1'b1;
        result_o.kind     = ihex_pkg::KIND_DONE;
        result_o.min_addr = low_q;
        result_o.max_addr = high_q;
      end else if (do_data) begin
        emit_o                = 1'b1;
        result_o.kind         = ihex_pkg::KIND_DATA;
        result_o.byte_address = daddr;
        result_o.data_byte    = b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q     <= '0;
      hold_q   <= '0;
      count_q  <= '0;
      offset_q <= '0;
      rkind_q  <= '0;
      hbad_q   <= 1'b0;
      idx_q    <= '0;
      ext_q    <= '0;
      upper_q  <= '0;
      base_q   <= '0;
      low_q    <= '1;
      high_q   <= '0;
      saw_q    <= 1'b0;
      stop_q   <= 1'b0;
    end else begin
      lp_q     <= lp_d;
      hold_q   <= hold_d;
      count_q  <= count_d;
      offset_q <= offset_d;
      rkind_q  <= rkind_d;
      hbad_q   <= hbad_d;
      idx_q    <= idx_d;
      ext_q    <= ext_d;
      upper_q  <= upper_d;
      base_q   <= base_d;
      low_q    <= low_d;
      high_q   <= high_d;
      saw_q    <= saw_d;
      stop_q   <= stop_d;
    end
  end

  assign stat_o.stopped = stop_q;
  assign line_pos_o     = lp_q;

endmodule

// ----- hdl/ihex_out_stage.sv -----
// Result register of the HEX record parser.
// Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                emit_i,
  input  ihex_pkg::out_item_t result_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ihex_pkg::out_item_t out_data_o
);

  logic                valid_q, valid_d;
  ihex_pkg::out_item_t data_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (fire_i) valid_d = emit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && emit_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- hdl/intel_hex_record_parser_top.sv -----
// Top level of the HEX record parser: input register, parser core, result register.
// Depends on ihex_pkg, ihex_in_stage, ihex_core and ihex_out_stage.
// Each character is held in the input register, and its result is registered in the result register.
// Throughput: one character per cycle while out_ready_i stays high; a result left waiting
// in the result register holds up the input until it is taken.
// Reset (rst_ni low, asynchronous): both stages empty, parser at the start of a line,
// lowest mark all ones, all other parser state zero; no clearing pass afterwards.
`timescale 1ns / 1ps

module intel_hex_record_parser_top #(
  parameter int unsigned LINE_LIMIT = ihex_pkg::LineLimitDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ihex_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ihex_pkg::out_item_t out_data_o
);

  localparam int unsigned LpW = $clog2(LINE_LIMIT + 1);

  // held character transaction
  logic               held_valid;
  ihex_pkg::in_item_t held_item;

  // a held character is consumed when the result register can take its result;
  // characters that cause no result are consumed the same way and leave nothing behind
  logic fire;
  logic space;

  logic                 emit;
  ihex_pkg::out_item_t  result;
  ihex_pkg::core_stat_t stat;
  logic [LpW-1:0]       line_pos;

  assign fire = held_valid && space;

  ihex_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (fire),
    .valid_o    (held_valid),
    .data_o     (held_item)
  );

  ihex_core #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (held_item),
    .emit_o     (emit),
    .result_o   (result),
    .stat_o     (stat),
    .line_pos_o (line_pos)
  );

  // the result register frees itself in the cycle its transaction is taken,
  // so the parser runs at full rate while out_ready_i is high; any stall with a
  // result waiting holds the parser for as long as it lasts
  ihex_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .emit_i      (emit),
    .result_i    (result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // a finish or error result leaves the parser stopped
  a_final_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind != ihex_pkg::KIND_DATA) |-> stat.stopped)
    else $error("final result without stopped parser");

  // once stopped, nothing more is produced
  a_quiet_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.stopped |-> !emit)
    else $error("result produced after stop");

  // the line counter never reaches the cut length
  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_pos < LpW'(LINE_LIMIT))
    else $error("line position out of range");

  // a stopped parser is always back at a line start or frozen mid-line, never advancing
  a_pos_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.stopped && $past(stat.stopped)) |-> $stable(line_pos))
    else $error("line position moved after stop");
`endif

endmodule
